FILE: src/spbar_pkg.sv
// ----------------------------------------------------------------------------
// spbar_pkg
// Shared types, widths and constants of the spectrum bar graph with peak hold.
// ----------------------------------------------------------------------------
`default_nettype none

package spbar_pkg;

  // geometry of the bar graph
  localparam int NUM_BANDS      = 12;
  localparam int LEDS_PER_BAND  = 8;
  localparam int LOW_BAND_COUNT = 2;

  // field widths
  localparam int BAND_W    = 4;
  localparam int MAG_W     = 15;
  localparam int DIV_W     = 15;
  localparam int LED_IDX_W = 7;
  localparam int HUE_W     = 14;
  localparam int SAT_W     = 8;
  localparam int BRIGHT_W  = 7;
  localparam int LEVEL_W   = 3;
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int ADDR_W    = $clog2(NUM_BANDS);
  localparam int ROW_W     = $clog2(LEDS_PER_BAND);
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int LED_SUM_W = BAND_W + ROW_W;
  localparam int CMP_W     = (ROW_W > LEVEL_W) ? ROW_W : LEVEL_W;

  // divide by 35 through a reciprocal: exact for values below 2^17
  localparam int RECIP_35    = 59919;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = 32;
  localparam int K_W         = 10;
  localparam int M_W         = 11;

  // constants of the color and level mapping
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = LEVEL_W'(7);
  localparam logic [BRIGHT_W-1:0] LOW_BRIGHT     = BRIGHT_W'(80);
  localparam logic [BRIGHT_W-1:0] HIGH_BRIGHT    = BRIGHT_W'(30);
  localparam logic [SAT_W-1:0]    SAT_FULL       = SAT_W'(255);
  localparam logic [DIV_W-1:0]    SAT_BASE       = DIV_W'(555);
  localparam logic [DIV_W-1:0]    HD_FLOOR       = DIV_W'(35);
  localparam logic [DIV_W-1:0]    LOW_HUE_DIV    = DIV_W'(10);
  localparam logic [DIV_W-1:0]    LOW_DIV_RESET  = DIV_W'(600);
  localparam logic [DIV_W-1:0]    HIGH_DIV_RESET = DIV_W'(55);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_DIV  = 1'b0,
    CFG_HIGH_DIV = 1'b1
  } cfg_reg_t;

  // control sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECAY,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

  // input request
  typedef struct packed {
    logic              command;
    logic [BAND_W-1:0] band_index;
    logic [MAG_W-1:0]  magnitude;
  } in_req_t;

  // one pixel result
  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    logic [HUE_W-1:0]     hue;
    logic [SAT_W-1:0]     saturation;
    logic [BRIGHT_W-1:0]  brightness;
    logic                 last_pixel;
  } out_pix_t;

  // level memory ports
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } lvl_rd_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] data;
  } lvl_wr_t;

  // divider start request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: src/spbar_level_mem.sv
// ----------------------------------------------------------------------------
// spbar_level_mem
// Held level store, one entry per band, one read and one write port, read
// data registered. A valid bit per entry makes unwritten entries read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module spbar_level_mem (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire spbar_pkg::lvl_rd_t           rd,
  input  wire spbar_pkg::lvl_wr_t           wr,
  output logic [spbar_pkg::LEVEL_W-1:0]     rd_data
);

  logic [spbar_pkg::LEVEL_W-1:0] mem_r [spbar_pkg::NUM_BANDS];
  logic [spbar_pkg::NUM_BANDS-1:0] valid_r;
  logic [spbar_pkg::LEVEL_W-1:0] rd_data_r;

  // entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= valid_r[rd.addr] ? mem_r[rd.addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/spbar_div.sv
// ----------------------------------------------------------------------------
// spbar_div
// Restoring divider, one quotient bit per cycle. Done pulses for a single cycle
// once the last step is registered; the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module spbar_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire spbar_pkg::div_req_t         req,
  output logic [spbar_pkg::DIV_W-1:0]      quotient,
  output logic                             done
);

  localparam int W = spbar_pkg::DIV_W;

  logic [W:0]                     rem_r;
  logic [W:0]                     rem_nxt;
  logic [W:0]                     shifted;
  logic [W-1:0]                   quo_r;
  logic [W-1:0]                   dvs_r;
  logic [spbar_pkg::CNT_W-1:0]    cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic                           fits;

  // one trial subtraction
  always_comb begin
    shifted = {rem_r[W-1:0], quo_r[W-1]};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? (shifted - {1'b0, dvs_r}) : shifted;
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + spbar_pkg::CNT_W'(1);
        if (cnt_r == spbar_pkg::CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

FILE: src/spectrum_bar_peak_hold_display_top.sv
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_display_top
// LED spectrum bar graph with per-band peak hold and frame decay.
// ----------------------------------------------------------------------------
// Held levels live in a small synchronous memory with registered read data.
// A frame tick sweeps that memory, one band per cycle, before the next
// request is taken. A band sample runs a read state (PREP), a start state
// (START), then three serial dividers in parallel (level, hue and
// saturation quotient) at one bit per cycle, and then streams LEDS_PER_BAND
// pixels, one per cycle when the output is not stalled. A sample whose band
// is out of range is dropped as it is accepted. Input stall is high for the
// whole of a request's work, up to the delivery of its last pixel.
`default_nettype none

module spectrum_bar_peak_hold_display_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire spbar_pkg::in_req_t                in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output spbar_pkg::out_pix_t                    out_data,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [spbar_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spbar_pkg::DIV_W-1:0]       cfg_data
);

  localparam int DW = spbar_pkg::DIV_W;
  localparam int LW = spbar_pkg::LEVEL_W;

  spbar_pkg::state_t state_r, state_nxt;

  logic [DW-1:0]                    ld_r, hd_r;
  logic [DW-1:0]                    ld_eff, hd_eff;
  logic [spbar_pkg::BAND_W-1:0]     band_r;
  logic [spbar_pkg::MAG_W-1:0]      mag_r;
  logic                             low_r;
  logic [spbar_pkg::K_W-1:0]        k_r;
  logic [spbar_pkg::M_W-1:0]        m_r;
  logic [spbar_pkg::PROD_W-1:0]     prod_k, prod_m;
  logic [spbar_pkg::ADDR_W-1:0]     sweep_r, dec_addr_r;
  logic                             dec_wb_r;
  logic [spbar_pkg::ROW_W-1:0]      row_r;
  logic [LW-1:0]                    held_r;
  logic [spbar_pkg::HUE_W-1:0]      hue_r;
  logic [spbar_pkg::SAT_W-1:0]      sat_r;
  logic [spbar_pkg::BRIGHT_W-1:0]   bright_r;

  logic                             in_acc, out_acc;
  logic                             band_bad;
  logic                             sweep_last, row_last;
  logic                             div_start, div_done;
  logic                             done_lvl, done_hue, done_sat;
  logic [DW-1:0]                    q_lvl, q_hue, q_sat;
  logic [LW-1:0]                    level_clip, held_upd, lvl_rd_data;
  logic [DW-1:0]                    sat_diff;
  logic [spbar_pkg::SAT_W-1:0]      sat_hi;
  logic [spbar_pkg::LED_SUM_W-1:0]  led_sum;
  logic                             lit;

  spbar_pkg::lvl_rd_t  lvl_rd;
  spbar_pkg::lvl_wr_t  lvl_wr;
  spbar_pkg::div_req_t req_lvl, req_hue, req_sat;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r <= spbar_pkg::LOW_DIV_RESET;
      hd_r <= spbar_pkg::HIGH_DIV_RESET;
    end else if (cfg_we) begin
      unique case (spbar_pkg::cfg_reg_t'(cfg_index))
        spbar_pkg::CFG_LOW_DIV:  ld_r <= cfg_data;
        spbar_pkg::CFG_HIGH_DIV: hd_r <= cfg_data;
      endcase
    end
  end

  // divider floors and the high divider scaled down by 35
  always_comb begin
    ld_eff = (ld_r == '0) ? DW'(1) : ld_r;
    hd_eff = (hd_r < spbar_pkg::HD_FLOOR) ? spbar_pkg::HD_FLOOR : hd_r;
    prod_k = spbar_pkg::PROD_W'(hd_eff) * spbar_pkg::PROD_W'(spbar_pkg::RECIP_35);
    prod_m = spbar_pkg::PROD_W'({hd_eff, 1'b0}) * spbar_pkg::PROD_W'(spbar_pkg::RECIP_35);
  end

  // request decode
  assign band_bad   = (32'(in_data.band_index) >= 32'(spbar_pkg::NUM_BANDS));
  assign sweep_last = (sweep_r == spbar_pkg::ADDR_W'(spbar_pkg::NUM_BANDS - 1));
  assign row_last   = (row_r == spbar_pkg::ROW_W'(spbar_pkg::LEDS_PER_BAND - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spbar_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_data.command) begin
            state_nxt = spbar_pkg::ST_DECAY;
          end else if (!band_bad) begin
            state_nxt = spbar_pkg::ST_PREP;
          end
        end
      end
      spbar_pkg::ST_DECAY: begin
        if (sweep_last) state_nxt = spbar_pkg::ST_IDLE;
      end
      spbar_pkg::ST_PREP:  state_nxt = spbar_pkg::ST_START;
      spbar_pkg::ST_START: state_nxt = spbar_pkg::ST_DIV;
      spbar_pkg::ST_DIV: begin
        if (div_done) state_nxt = spbar_pkg::ST_EMIT;
      end
      spbar_pkg::ST_EMIT: begin
        if (out_acc && row_last) state_nxt = spbar_pkg::ST_IDLE;
      end
      default: state_nxt = spbar_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spbar_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != spbar_pkg::ST_IDLE);
    out_valid = (state_r == spbar_pkg::ST_EMIT);
    div_start = (state_r == spbar_pkg::ST_START);
    lvl_rd.en   = (state_r == spbar_pkg::ST_PREP) || (state_r == spbar_pkg::ST_DECAY);
    lvl_rd.addr = (state_r == spbar_pkg::ST_DECAY) ? sweep_r
                                                   : spbar_pkg::ADDR_W'(band_r);
  end

  // level memory write: decay write-back, else sample peak update
  always_comb begin
    if (dec_wb_r) begin
      lvl_wr.en   = 1'b1;
      lvl_wr.addr = dec_addr_r;
      lvl_wr.data = (lvl_rd_data != '0) ? (lvl_rd_data - LW'(1)) : lvl_rd_data;
    end else begin
      lvl_wr.en   = (state_r == spbar_pkg::ST_DIV) && div_done;
      lvl_wr.addr = spbar_pkg::ADDR_W'(band_r);
      lvl_wr.data = held_upd;
    end
  end

  // decay sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_wb_r <= 1'b0;
      sweep_r  <= '0;
    end else begin
      dec_wb_r <= (state_r == spbar_pkg::ST_DECAY);
      if (state_r == spbar_pkg::ST_IDLE) begin
        sweep_r <= '0;
      end else if (state_r == spbar_pkg::ST_DECAY) begin
        sweep_r <= sweep_r + spbar_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    dec_addr_r <= sweep_r;
  end

  // request capture and scaled dividers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      band_r <= in_data.band_index;
      mag_r  <= in_data.magnitude;
      low_r  <= (32'(in_data.band_index) < 32'(spbar_pkg::LOW_BAND_COUNT));
    end
    if (state_r == spbar_pkg::ST_PREP) begin
      k_r <= prod_k[spbar_pkg::RECIP_SHIFT +: spbar_pkg::K_W];
      m_r <= prod_m[spbar_pkg::RECIP_SHIFT +: spbar_pkg::M_W];
    end
  end

  // divider requests
  always_comb begin
    req_lvl.start    = div_start;
    req_lvl.dividend = DW'(mag_r);
    req_lvl.divisor  = low_r ? ld_eff : hd_eff;
    req_hue.start    = div_start;
    req_hue.dividend = DW'(mag_r);
    req_hue.divisor  = low_r ? spbar_pkg::LOW_HUE_DIV : DW'(m_r);
    req_sat.start    = div_start;
    req_sat.dividend = DW'(mag_r);
    req_sat.divisor  = DW'(k_r);
  end

  spbar_div u_div_lvl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_lvl),
    .quotient (q_lvl),
    .done     (done_lvl)
  );

  spbar_div u_div_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_hue),
    .quotient (q_hue),
    .done     (done_hue)
  );

  spbar_div u_div_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_sat),
    .quotient (q_sat),
    .done     (done_sat)
  );

  assign div_done = done_lvl && done_hue && done_sat;

  spbar_level_mem u_level_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (lvl_rd),
    .wr      (lvl_wr),
    .rd_data (lvl_rd_data)
  );

  // clipped level, peak hold and high band saturation
  always_comb begin
    level_clip = (q_lvl > DW'(spbar_pkg::LEVEL_MAX)) ? spbar_pkg::LEVEL_MAX : q_lvl[LW-1:0];
    held_upd   = (lvl_rd_data < level_clip) ? level_clip : lvl_rd_data;
    sat_diff   = spbar_pkg::SAT_BASE - q_sat;
    if (q_sat >= spbar_pkg::SAT_BASE) begin
      sat_hi = '0;
    end else if (sat_diff > DW'(spbar_pkg::SAT_FULL)) begin
      sat_hi = spbar_pkg::SAT_FULL;
    end else begin
      sat_hi = sat_diff[spbar_pkg::SAT_W-1:0];
    end
  end

  // pixel color and row counter
  always_ff @(posedge clk) begin
    if ((state_r == spbar_pkg::ST_DIV) && div_done) begin
      held_r   <= held_upd;
      hue_r    <= q_hue[spbar_pkg::HUE_W-1:0];
      sat_r    <= low_r ? spbar_pkg::SAT_FULL : sat_hi;
      bright_r <= low_r ? spbar_pkg::LOW_BRIGHT : spbar_pkg::HIGH_BRIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if ((state_r == spbar_pkg::ST_DIV) && div_done) begin
      row_r <= '0;
    end else if (out_acc) begin
      row_r <= row_r + spbar_pkg::ROW_W'(1);
    end
  end

  // pixel result
  always_comb begin
    led_sum = spbar_pkg::LED_SUM_W'(band_r) * spbar_pkg::LED_SUM_W'(spbar_pkg::LEDS_PER_BAND)
            + spbar_pkg::LED_SUM_W'(row_r);
    lit     = (spbar_pkg::CMP_W'(row_r) < spbar_pkg::CMP_W'(held_r));
    out_data.led_index  = spbar_pkg::LED_IDX_W'(led_sum);
    out_data.hue        = lit ? hue_r : '0;
    out_data.saturation = lit ? sat_r : '0;
    out_data.brightness = lit ? bright_r : '0;
    out_data.last_pixel = row_last;
  end

endmodule

`default_nettype wire

FILE: tb/sv/spectrum_bar_peak_hold_display_top_tb.sv
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_display_top_tb
// Self-checking bench for the spectrum bar graph with peak hold and decay.
// A short table of directed requests is followed by random phases, each under
// its own pair of divider settings. Requests and pixels move with random gaps
// and stalls. Every pixel is predicted and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectrum_bar_peak_hold_display_top_tb;
  import spbar_pkg::*;

  // request commands
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // color and level mapping
  localparam int unsigned LVL_TOP    = 7;
  localparam int unsigned BRIGHT_LO  = 80;
  localparam int unsigned BRIGHT_HI  = 30;
  localparam int unsigned SAT_TOP    = 255;
  localparam int unsigned SAT_OFS    = 555;
  localparam int unsigned HD_MIN     = 35;
  localparam int unsigned HUE_LO_DIV = 10;
  localparam int unsigned MAG_TOP    = 32767;
  localparam int unsigned BAND_TOP   = 15;

  // run control
  localparam int PAUSE_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 32;

  // one request plus an optional typed-in expectation
  typedef struct packed {
    in_req_t             req;
    logic                typed;
    logic [LEVEL_W-1:0]  lit;
    logic [HUE_W-1:0]    hue;
    logic [SAT_W-1:0]    sat;
    logic [BRIGHT_W-1:0] bright;
  } bar_stim_t;

  // directed requests under reset dividers (600 low, 55 high)
  // columns: {command, band, magnitude}, typed, lit rows, hue, saturation, brightness
  localparam int DIR_N = 25;
  localparam bar_stim_t DIRECTED [DIR_N] = '{
    '{'{CMD_SAMPLE, 4'd0,  15'd0},     1'b1, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd0,  15'd32767}, 1'b1, 3'd7, 14'd3276,  8'd255, 7'd80},
    '{'{CMD_SAMPLE, 4'd11, 15'd32767}, 1'b1, 3'd7, 14'd10922, 8'd0,   7'd30},
    '{'{CMD_SAMPLE, 4'd2,  15'd0},     1'b1, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd0,  15'd0},     1'b1, 3'd6, 14'd0,     8'd255, 7'd80},
    '{'{CMD_SAMPLE, 4'd11, 15'd0},     1'b1, 3'd6, 14'd0,     8'd255, 7'd30},
    '{'{CMD_SAMPLE, 4'd12, 15'd100},   1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd15, 15'd32767}, 1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd5,  15'd100},   1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd3,  15'd54},    1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd3,  15'd55},    1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd1,  15'd1199},  1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd1,  15'd1200},  1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd6,  15'd385},   1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd7,  15'd16384}, 1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd15, 15'd32767}, 1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_TICK,   4'd0,  15'd0},     1'b0, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd0,  15'd0},     1'b1, 3'd0, 14'd0,     8'd0,   7'd0},
    '{'{CMD_SAMPLE, 4'd11, 15'd0},     1'b1, 3'd0, 14'd0,     8'd0,   7'd0}
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_req_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_pix_t         out_data;
  logic             cfg_we    = 1'b0;
  cfg_reg_t         cfg_index = CFG_LOW_DIV;
  logic [DIV_W-1:0] cfg_data  = '0;

  // requests waiting to go out, pixels waiting to come back
  bar_stim_t          request_fifo[$];
  out_pix_t           pixel_fifo[$];
  out_pix_t           pixel_due;

  // predicted block state
  logic [LEVEL_W-1:0] bar_level [NUM_BANDS];
  logic [DIV_W-1:0]   low_div_q;
  logic [DIV_W-1:0]   high_div_q;

  bit idling_on   = 1'b1;
  int fail_count  = 0;
  int quiet_cycles = 0;
  int in_gap      = 0;
  int stall_left  = 0;

  spectrum_bar_peak_hold_display_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // update the held levels and queue the pixels one request produces
  task automatic predict_bar(input bar_stim_t s);
    int unsigned mag, band, ld, hd, q, hue, sat, bright, lvl;
    int b, row;
    out_pix_t pix;
    mag  = s.req.magnitude;
    band = s.req.band_index;
    if (s.req.command == CMD_TICK) begin
      for (b = 0; b < NUM_BANDS; b++)
        if (bar_level[b] != '0) bar_level[b] = bar_level[b] - 1'b1;
      return;
    end
    if (band >= NUM_BANDS) return;
    if (band < LOW_BAND_COUNT) begin
      ld     = (low_div_q == '0) ? 1 : low_div_q;
      hue    = mag / HUE_LO_DIV;
      sat    = SAT_TOP;
      bright = BRIGHT_LO;
      lvl    = mag / ld;
    end else begin
      hd     = (high_div_q < HD_MIN) ? HD_MIN : high_div_q;
      q      = mag / (hd / HD_MIN);
      hue    = mag / (2 * hd / HD_MIN);
      sat    = (q >= SAT_OFS) ? 0 : SAT_OFS - q;
      if (sat > SAT_TOP) sat = SAT_TOP;
      bright = BRIGHT_HI;
      lvl    = mag / hd;
    end
    if (lvl > LVL_TOP) lvl = LVL_TOP;
    if (bar_level[band] < lvl) bar_level[band] = LEVEL_W'(lvl);
    // typed-in rows replace the computed colors
    if (s.typed) begin
      lvl    = s.lit;
      hue    = s.hue;
      sat    = s.sat;
      bright = s.bright;
    end else begin
      lvl = bar_level[band];
    end
    for (row = 0; row < LEDS_PER_BAND; row++) begin
      pix.led_index  = LED_IDX_W'(band * LEDS_PER_BAND + row);
      pix.hue        = (row < lvl) ? HUE_W'(hue) : '0;
      pix.saturation = (row < lvl) ? SAT_W'(sat) : '0;
      pix.brightness = (row < lvl) ? BRIGHT_W'(bright) : '0;
      pix.last_pixel = (row == LEDS_PER_BAND - 1);
      pixel_fifo.push_back(pix);
    end
  endtask

  // magnitude step of the high band saturation formula
  function automatic int unsigned hd_scale();
    int unsigned hd;
    hd = (high_div_q < HD_MIN) ? HD_MIN : high_div_q;
    return hd / HD_MIN;
  endfunction

  // magnitude spread over the levels of the band's current divider
  function automatic int unsigned pick_magnitude(input int unsigned band);
    int unsigned dv, lim;
    if (band < LOW_BAND_COUNT) dv = (low_div_q == '0) ? 1 : low_div_q;
    else dv = (high_div_q < HD_MIN) ? HD_MIN : high_div_q;
    lim = 8 * dv;
    if (lim > MAG_TOP) lim = MAG_TOP;
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, MAG_TOP);
      1:       return $urandom_range(0, 1) ? MAG_TOP : 0;
      2:       return SAT_OFS * (hd_scale()) + $urandom_range(0, 2) - 1;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  task automatic write_divider(input cfg_reg_t idx, input logic [DIV_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_LOW_DIV) low_div_q = value;
    else high_div_q = value;
  endtask

  // wait until every request is taken and every pixel is back, then let
  // a tick sweep or a dropped request finish
  task automatic settle();
    while (request_fifo.size() != 0 || pixel_fifo.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  // random requests: mostly in-range samples, some ticks, a few bad bands
  task automatic run_random(input int count);
    bar_stim_t s;
    int made;
    made = 0;
    while (made < count) begin
      s = '0;
      s.req.command = ($urandom_range(0, 5) == 0) ? CMD_TICK : CMD_SAMPLE;
      if ($urandom_range(0, 9) == 0)
        s.req.band_index = BAND_W'($urandom_range(NUM_BANDS, BAND_TOP));
      else
        s.req.band_index = BAND_W'($urandom_range(0, NUM_BANDS - 1));
      s.req.magnitude = MAG_W'(pick_magnitude(s.req.band_index));
      if (s.req.command == CMD_TICK || s.req.band_index < NUM_BANDS) made++;
      request_fifo.push_back(s);
    end
  endtask

  // request driver with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_bar(request_fifo.pop_front());
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (request_fifo.size() != 0 && idling_on && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (request_fifo.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= request_fifo[0].req;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel checker with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_fifo.size() == 0) begin
          $error("unexpected pixel at led_index %0d", out_data.led_index);
          fail_count++;
        end else begin
          pixel_due = pixel_fifo.pop_front();
          compare_field("led_index", pixel_due.led_index, out_data.led_index);
          compare_field("hue", pixel_due.hue, out_data.hue);
          compare_field("saturation", pixel_due.saturation, out_data.saturation);
          compare_field("brightness", pixel_due.brightness, out_data.brightness);
          compare_field("last_pixel", pixel_due.last_pixel, out_data.last_pixel);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted request or pixel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** spectrum_bar_peak_hold_display_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sequence: reset, directed table, random phases under several dividers
  initial begin
    int unsigned lo, hi;
    for (int b = 0; b < NUM_BANDS; b++) bar_level[b] = '0;
    low_div_q  = DIV_W'(600);
    high_div_q = DIV_W'(55);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) request_fifo.push_back(DIRECTED[i]);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lo = 0;     hi = 0;     end
        1: begin lo = 1;     hi = 34;    end
        2: begin lo = 32767; hi = 32767; end
        3: begin lo = 600;   hi = 35;    end
        4: begin lo = $urandom_range(1, 4000); hi = 69; end
        5: begin lo = $urandom_range(1, 4000); hi = 70; end
        default: begin
          lo = $urandom_range(0, 32767) >> $urandom_range(0, 14);
          hi = $urandom_range(0, 4000);
        end
      endcase
      write_divider(CFG_LOW_DIV, DIV_W'(lo));
      write_divider(CFG_HIGH_DIV, DIV_W'(hi));
      // last phase runs flat out
      idling_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_random(ITEMS_PER_PHASE);
      settle();
    end

    if (fail_count == 0 && pixel_fifo.size() == 0) begin
      $display("** spectrum_bar_peak_hold_display_top: PASSED **");
    end else begin
      $display("** spectrum_bar_peak_hold_display_top: FAILED **");
    end
    $finish;
  end

endmodule
